[rtl/core/dcipid_pkg.sv]
// Shared types and constants for the two-channel incremental PID controller.
package dcipid_pkg;

  localparam int CountWidth    = 16;
  localparam int ErrWidth      = 17;
  localparam int Diff1Width    = 18;
  localparam int Diff2Width    = 19;
  localparam int GainWidth     = 8;
  localparam int AccWidth      = 28;
  localparam int OpAWidth      = 28;
  localparam int OpBWidth      = GainWidth + 1;
  localparam int ProdWidth     = OpAWidth + OpBWidth;
  localparam int OutWidth      = 32;
  localparam int CfgIndexWidth = 4;
  localparam int NumChannels   = 2;

  localparam logic [GainWidth-1:0] KpReset    = 8'd12;
  localparam logic [GainWidth-1:0] KiReset    = 8'd3;
  localparam logic [GainWidth-1:0] KdReset    = 8'd2;
  localparam logic [GainWidth-1:0] ScaleReset = 8'd1;

  localparam logic [OutWidth-1:0] OutMax = {1'b0, {(OutWidth-1){1'b1}}};
  localparam logic [OutWidth-1:0] OutMin = {1'b1, {(OutWidth-1){1'b0}}};

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_KP    = 4'd0,
    REG_KI    = 4'd1,
    REG_KD    = 4'd2,
    REG_SCALE = 4'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_MUL_S,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SEL_P,
    SEL_I,
    SEL_D,
    SEL_S
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     diff;
    logic     mac_en;
    logic     mac_first;
    logic     scale_en;
    mul_sel_t sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

[rtl/core/dcipid_ctrl.sv]
// Sequencing state machine for the PID datapath.
module dcipid_ctrl
  import dcipid_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DIFF;
      end
      ST_DIFF:  state_next = ST_MUL_P;
      ST_MUL_P: state_next = ST_MUL_I;
      ST_MUL_I: state_next = ST_MUL_D;
      ST_MUL_D: state_next = ST_MUL_S;
      ST_MUL_S: state_next = ST_DONE;
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    cmd           = '0;
    cmd.sel       = SEL_P;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_DIFF: begin
        cmd.diff = 1'b1;
      end
      ST_MUL_P: begin
        cmd.sel       = SEL_P;
        cmd.mac_en    = 1'b1;
        cmd.mac_first = 1'b1;
      end
      ST_MUL_I: begin
        cmd.sel    = SEL_I;
        cmd.mac_en = 1'b1;
      end
      ST_MUL_D: begin
        cmd.sel    = SEL_D;
        cmd.mac_en = 1'b1;
      end
      ST_MUL_S: begin
        cmd.sel      = SEL_S;
        cmd.scale_en = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

[rtl/core/dcipid_dp.sv]
// Datapath: gains, error history, shared multiplier, accumulator and output register.
module dcipid_dp
  import dcipid_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  input  logic                     channel,
  input  logic [CountWidth-1:0]    target_count,
  input  logic [CountWidth-1:0]    measured_count,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [GainWidth-1:0]     cfg_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [OutWidth-1:0]      out_data
);

  logic [GainWidth-1:0] kp;
  logic [GainWidth-1:0] ki;
  logic [GainWidth-1:0] kd;
  logic [GainWidth-1:0] scale;

  logic signed [ErrWidth-1:0] hist_last [NumChannels];
  logic signed [ErrWidth-1:0] hist_prev [NumChannels];

  logic                         chan;
  logic signed [ErrWidth-1:0]   err;
  logic signed [ErrWidth-1:0]   e1;
  logic signed [ErrWidth-1:0]   e2;
  logic signed [Diff1Width-1:0] d1;
  logic signed [Diff2Width-1:0] d2;
  logic signed [AccWidth-1:0]   acc;
  logic signed [ProdWidth-1:0]  scaled;

  logic signed [OpAWidth-1:0]  op_a;
  logic signed [OpBWidth-1:0]  op_b;
  logic signed [ProdWidth-1:0] prod;
  logic signed [ErrWidth-1:0]  err_new;
  logic                        fits;
  logic [OutWidth-1:0]         sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp    <= KpReset;
      ki    <= KiReset;
      kd    <= KdReset;
      scale <= ScaleReset;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_KP:    kp    <= cfg_data;
        REG_KI:    ki    <= cfg_data;
        REG_KD:    kd    <= cfg_data;
        REG_SCALE: scale <= cfg_data;
        default:   ;
      endcase
    end
  end

  assign err_new = $signed({target_count[CountWidth-1], target_count})
                 - $signed({measured_count[CountWidth-1], measured_count});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chan <= channel;
      err  <= err_new;
      e1   <= hist_last[channel];
      e2   <= hist_prev[channel];
    end
    if (cmd.diff) begin
      d1 <= Diff1Width'(err) - Diff1Width'(e1);
      d2 <= Diff2Width'(err) - (Diff2Width'(e1) <<< 1) + Diff2Width'(e2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumChannels; i++) begin
        hist_last[i] <= '0;
        hist_prev[i] <= '0;
      end
    end else if (cmd.diff) begin
      hist_prev[chan] <= e1;
      hist_last[chan] <= err;
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_P: begin
        op_a = OpAWidth'(d1);
        op_b = $signed({1'b0, kp});
      end
      SEL_I: begin
        op_a = OpAWidth'(err);
        op_b = $signed({1'b0, ki});
      end
      SEL_D: begin
        op_a = OpAWidth'(d2);
        op_b = $signed({1'b0, kd});
      end
      default: begin
        op_a = OpAWidth'(acc);
        op_b = $signed({1'b0, scale});
      end
    endcase
  end

  assign prod = op_a * op_b;

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      if (cmd.mac_first) begin
        acc <= AccWidth'(prod);
      end else begin
        acc <= acc + AccWidth'(prod);
      end
    end
    if (cmd.scale_en) begin
      scaled <= prod;
    end
  end

  assign fits = (scaled[ProdWidth-1:OutWidth-1] == '0)
             || (scaled[ProdWidth-1:OutWidth-1] == '1);

  always_comb begin
    if (fits) begin
      sat = scaled[OutWidth-1:0];
    end else if (scaled[ProdWidth-1]) begin
      sat = OutMin;
    end else begin
      sat = OutMax;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= sat;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

[rtl/core/dual_channel_incremental_pid.sv]
// Top level of the two-channel incremental PID controller.
// Each input transaction selects a channel on s_tuser and carries a target and a measured
// encoder count; the block answers with one signed 32-bit drive increment,
// scale * (kp*(e-e1) + ki*e + kd*(e-2*e1+e2)) saturated to 32 bits, and then shifts that
// channel's error history. One multiplier is shared over the three gain terms and the output
// scale, so the four products follow each other in ST_MUL_P, ST_MUL_I, ST_MUL_D and ST_MUL_S
// after ST_DIFF forms the differences. The block takes no new item until the last result
// has been loaded into the output register. A new item is taken while a finished result still
// waits on the output; its result then holds until the output register is free. Gains must be
// written by the user through the cfg port only while the block is idle; the block itself
// does not enforce it. Indexes beyond the list are ignored.
module dual_channel_incremental_pid
  import dcipid_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [31:0]              s_tdata,   // target_count[15:0], measured_count[31:16]
  input  logic                     s_tuser,   // channel[0]
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OutWidth-1:0]      m_tdata,   // drive_increment[31:0]
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [GainWidth-1:0]     cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  dcipid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dcipid_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .channel        (s_tuser),
    .target_count   (s_tdata[CountWidth-1:0]),
    .measured_count (s_tdata[2*CountWidth-1:CountWidth]),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_data       (m_tdata)
  );

endmodule

[tb/tb_dual_channel_incremental_pid.sv]
// Testbench for the two-channel incremental PID controller with its own predictor.
`timescale 1ns / 1ps

module tb_dual_channel_incremental_pid;
  import dcipid_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int RandomBlocks = 19;
  localparam int BlockItems = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutWidth-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [GainWidth-1:0] cfg_data = '0;

  logic [GainWidth-1:0] kp_gain = KpReset;
  logic [GainWidth-1:0] ki_gain = KiReset;
  logic [GainWidth-1:0] kd_gain = KdReset;
  logic [GainWidth-1:0] scale_gain = ScaleReset;
  logic signed [ErrWidth-1:0] last_err [NumChannels] = '{default: '0};
  logic signed [ErrWidth-1:0] prev_err [NumChannels] = '{default: '0};

  logic [OutWidth-1:0] drive_expected [$];
  logic [OutWidth-1:0] drive_want;

  int src_idle_pct = 29;
  int sink_stall_pct = 71;
  int cycle_count = 0;
  int errors = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;

  dual_channel_incremental_pid dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (drive_expected.size() == 0) begin
        $error("drive_increment: unexpected result, expected none, actual %0d",
               $signed(m_tdata));
        errors++;
      end else begin
        drive_want = drive_expected.pop_front();
        results_checked++;
        if (m_tdata !== drive_want) begin
          $error("drive_increment mismatch: expected %0d, actual %0d",
                 $signed(drive_want), $signed(m_tdata));
          errors++;
        end
      end
    end
  end

  function automatic logic [OutWidth-1:0] predict_drive(input logic ch,
                                                        input logic signed [CountWidth-1:0] tgt,
                                                        input logic signed [CountWidth-1:0] meas);
    longint err;
    longint e1;
    longint e2;
    longint acc;
    err = longint'(tgt) - longint'(meas);
    e1 = longint'(last_err[ch]);
    e2 = longint'(prev_err[ch]);
    acc = longint'(kp_gain) * (err - e1) + longint'(ki_gain) * err
        + longint'(kd_gain) * (err - 2 * e1 + e2);
    acc = acc * longint'(scale_gain);
    prev_err[ch] = last_err[ch];
    last_err[ch] = err[ErrWidth-1:0];
    if (acc > 64'sd2147483647) return OutMax;
    if (acc < -64'sd2147483648) return OutMin;
    return acc[OutWidth-1:0];
  endfunction

  task automatic send_sample(input logic ch, input logic signed [CountWidth-1:0] tgt,
                             input logic signed [CountWidth-1:0] meas);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= ch;
    s_tdata <= {meas, tgt};
    do @(posedge clk); while (!s_tready);
    drive_expected.push_back(predict_drive(ch, tgt, meas));
    samples_sent++;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (drive_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [GainWidth-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    case (idx)
      REG_KP: kp_gain = val;
      REG_KI: ki_gain = val;
      REG_KD: kd_gain = val;
      REG_SCALE: scale_gain = val;
      default: ;
    endcase
  endtask

  task automatic set_gains(input logic [GainWidth-1:0] kp, input logic [GainWidth-1:0] ki,
                           input logic [GainWidth-1:0] kd, input logic [GainWidth-1:0] sc,
                           input bit every_spare = 1'b0);
    drain();
    if (every_spare) begin
      for (int idx = REG_SCALE + 1; idx < (1 << CfgIndexWidth); idx++) begin
        write_reg(CfgIndexWidth'(idx), GainWidth'($urandom));
      end
    end else begin
      write_reg(CfgIndexWidth'($urandom_range((1 << CfgIndexWidth) - 1, REG_SCALE + 1)),
                GainWidth'($urandom));
    end
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_SCALE, sc);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [GainWidth-1:0] random_gain(input int mode);
    case (mode)
      0: return $urandom_range(1) ? 8'hFF : 8'h00;
      1: return GainWidth'($urandom);
      default: return GainWidth'($urandom_range(15));
    endcase
  endfunction

  function automatic logic [CountWidth-1:0] corner_count();
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  task automatic test_reset_defaults;
    send_sample(1'b0, 16'sd100, 16'sd40);
    send_sample(1'b1, -16'sd200, 16'sd50);
    send_sample(1'b0, 16'sd100, 16'sd100);
    send_sample(1'b1, 16'sd0, 16'sd0);
  endtask

  task automatic test_error_extremes;
    send_sample(1'b0, 16'sh7FFF, 16'sh8000);
    send_sample(1'b0, 16'sh8000, 16'sh7FFF);
    send_sample(1'b1, 16'sh8000, 16'sh7FFF);
    send_sample(1'b1, 16'sh7FFF, 16'sh8000);
    send_sample(1'b0, 16'sd0, 16'sd0);
  endtask

  task automatic test_saturation;
    set_gains(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_sample(1'b0, 16'sh7FFF, 16'sh8000);
    send_sample(1'b0, 16'sh8000, 16'sh7FFF);
    send_sample(1'b1, 16'sh8000, 16'sh7FFF);
    send_sample(1'b1, 16'sd1, 16'sd0);
  endtask

  task automatic test_zero_scale;
    set_gains(8'hFF, 8'h00, 8'hFF, 8'h00);
    send_sample(1'b0, 16'sd5000, -16'sd3000);
    send_sample(1'b1, -16'sd1234, 16'sd4321);
    set_gains(KpReset, KiReset, KdReset, ScaleReset);
    send_sample(1'b0, 16'sd0, 16'sd0);
    send_sample(1'b1, 16'sd0, 16'sd0);
  endtask

  task automatic test_zero_gains;
    set_gains(8'h00, 8'h00, 8'h00, 8'hFF);
    send_sample(1'b0, 16'sh7FFF, 16'sh8000);
    send_sample(1'b1, 16'sh8000, 16'sh7FFF);
  endtask

  task automatic test_spare_indexes;
    set_gains(8'd7, 8'd1, 8'd4, 8'd2, 1'b1);
    send_sample(1'b0, 16'sd300, -16'sd20);
    send_sample(1'b1, -16'sd77, 16'sd900);
    send_sample(1'b0, 16'sd10, 16'sd310);
  endtask

  task automatic test_random_traffic;
    int mode;
    logic ch;
    logic signed [CountWidth-1:0] tgt;
    logic signed [CountWidth-1:0] meas;
    for (int blk = 0; blk < RandomBlocks; blk++) begin
      if (blk < 6) begin
        src_idle_pct = 29;
        sink_stall_pct = 71;
      end else if (blk < 12) begin
        src_idle_pct = 71;
        sink_stall_pct = 29;
      end else begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
      mode = $urandom_range(2);
      set_gains(random_gain(mode), random_gain(mode), random_gain(mode), random_gain(mode));
      for (int n = 0; n < BlockItems; n++) begin
        ch = 1'($urandom_range(1));
        case ($urandom_range(3))
          0: begin
            tgt = CountWidth'($urandom);
            meas = CountWidth'($urandom);
          end
          1: begin
            tgt = corner_count();
            meas = corner_count();
          end
          default: begin
            meas = CountWidth'($urandom);
            tgt = meas + CountWidth'(int'($urandom_range(64)) - 32);
          end
        endcase
        send_sample(ch, tgt, meas);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_error_extremes();
    test_saturation();
    test_zero_scale();
    test_zero_gains();
    test_spare_indexes();
    test_random_traffic();
    drain();
    $display("Sent %0d samples over both channels and checked %0d drive increments.",
             samples_sent, results_checked);
    $display("Made %0d register writes, spare indexes included, under three idle profiles.",
             reg_writes);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
